FILE: rtl/core/spim_pkg.sv
// shared constants, codes and types of the spi master with length header
`default_nettype none
package spim_pkg;

   localparam int MaxBits    = 32;
   localparam int HeaderBits = 8;
   localparam int WordW      = 32;
   localparam int CountW     = 6;
   localparam int HalfW      = 16;
   localparam int HdrVecW    = 16;
   localparam int CsrIndexW  = 1;
   localparam int ReqDataW   = 40;
   localparam int RspDataW   = 40;

   localparam logic [HalfW-1:0]  HalfPeriodReset   = 16'd250;
   localparam logic              HeaderEnableReset = 1'b1;
   localparam logic [CountW-1:0] DefaultCount      = 6'd8;
   localparam logic [CountW-1:0] HeaderLast        = CountW'(HeaderBits - 1);

   // register indexes on the csr port
   localparam logic [CsrIndexW-1:0] CSR_HALF_PERIOD   = 1'b0;
   localparam logic [CsrIndexW-1:0] CSR_HEADER_ENABLE = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_HEAD = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   typedef struct packed {
      logic [HalfW-1:0] half_period;
      logic             header_enable;
   } cfg_type;

   typedef struct packed {
      logic [WordW-1:0] received_word;
      logic             done_res;
      logic             busy_res;
      logic             cs_two_n;
      logic             cs_one_n;
      logic             mosi;
      logic             sclk;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/core/spim_csr.sv
// configuration registers: half period and header enable
`default_nettype none
module spim_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [spim_pkg::CsrIndexW-1:0]  csr_index,
   input  wire logic [spim_pkg::HalfW-1:0]      csr_data,
   output      spim_pkg::cfg_type               cfg
);
   import spim_pkg::*;

   logic [HalfW-1:0] half_period_ff, half_period_in;
   logic             header_enable_ff, header_enable_in;

   assign csr_ready = 1'b1;

   always_comb begin
      half_period_in   = half_period_ff;
      header_enable_in = header_enable_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HALF_PERIOD:   half_period_in   = csr_data;
            CSR_HEADER_ENABLE: header_enable_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff   <= HalfPeriodReset;
         header_enable_ff <= HeaderEnableReset;
      end else begin
         half_period_ff   <= half_period_in;
         header_enable_ff <= header_enable_in;
      end
   end

   assign cfg.half_period   = half_period_ff;
   assign cfg.header_enable = header_enable_ff;

endmodule
`default_nettype wire

FILE: rtl/core/spim_engine.sv
// pin timing engine: one tick of spi state per accepted transaction
`default_nettype none
module spim_engine (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        tick,
   input  wire logic                        start_req,
   input  wire logic                        slave_select,
   input  wire logic [spim_pkg::WordW-1:0]  send_word,
   input  wire logic [spim_pkg::CountW-1:0] bit_count,
   input  wire logic                        miso_bit,
   input  wire spim_pkg::cfg_type           cfg,
   output      spim_pkg::result_type        result
);
   import spim_pkg::*;

   phase_type         phase_ff, phase_in;
   logic              clock_high_ff, clock_high_in;
   logic [CountW-1:0] bit_index_ff, bit_index_in;
   logic [HalfW-1:0]  tick_count_ff, tick_count_in;
   logic [WordW-1:0]  out_shift_ff, out_shift_in;
   logic [WordW-1:0]  in_shift_ff, in_shift_in;
   logic [CountW-1:0] length_ff, length_in;
   logic              target_ff, target_in;

   logic [HalfW-1:0]   tick_sum;
   logic [HalfW-1:0]   hp;
   logic [CountW-1:0]  count_fixed;
   logic [HdrVecW-1:0] hdr_vec;
   logic               done;
   logic               busy;
   logic               mosi_bit;

   assign tick_sum = tick_count_ff + HalfW'(1);
   assign hp       = (cfg.half_period == '0) ? HalfW'(1) : cfg.half_period;
   assign count_fixed = (bit_count == '0 || {1'b0, bit_count} > (CountW+1)'(MaxBits))
                        ? DefaultCount : bit_count;

   always_comb begin
      phase_in      = phase_ff;
      clock_high_in = clock_high_ff;
      bit_index_in  = bit_index_ff;
      tick_count_in = tick_count_ff;
      out_shift_in  = out_shift_ff;
      in_shift_in   = in_shift_ff;
      length_in     = length_ff;
      target_in     = target_ff;
      done          = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               length_in     = count_fixed;
               target_in     = slave_select;
               out_shift_in  = send_word;
               in_shift_in   = '0;
               clock_high_in = 1'b0;
               tick_count_in = '0;
               if (cfg.header_enable) begin
                  phase_in     = PH_HEAD;
                  bit_index_in = HeaderLast;
               end else begin
                  phase_in     = PH_DATA;
                  bit_index_in = count_fixed - CountW'(1);
               end
            end
         end
         PH_HEAD, PH_DATA: begin
            tick_count_in = tick_sum;
            if (tick_sum >= hp) begin
               tick_count_in = '0;
               if (!clock_high_ff) begin
                  clock_high_in = 1'b1;
               end else begin
                  clock_high_in = 1'b0;
                  // sample on the falling edge; header bits are not sampled
                  if (phase_ff == PH_DATA && miso_bit && !bit_index_ff[CountW-1]) begin
                     in_shift_in[bit_index_ff[CountW-2:0]] = 1'b1;
                  end
                  if (bit_index_ff != '0) begin
                     bit_index_in = bit_index_ff - CountW'(1);
                  end else if (phase_ff == PH_HEAD) begin
                     phase_in     = PH_DATA;
                     bit_index_in = length_ff - CountW'(1);
                  end else begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // pin levels shown after this tick
   assign hdr_vec = HdrVecW'(length_in);
   assign busy    = (phase_in != PH_IDLE);

   always_comb begin
      mosi_bit = 1'b0;
      if (phase_in == PH_HEAD) begin
         if (bit_index_in < CountW'(HdrVecW)) begin
            mosi_bit = hdr_vec[bit_index_in[3:0]];
         end
      end else if (phase_in == PH_DATA) begin
         if (!bit_index_in[CountW-1]) begin
            mosi_bit = out_shift_in[bit_index_in[CountW-2:0]];
         end
      end
   end

   assign result.sclk          = busy & clock_high_in;
   assign result.mosi          = busy & mosi_bit;
   assign result.cs_one_n      = !(busy && !target_in);
   assign result.cs_two_n      = !(busy && target_in);
   assign result.busy_res      = busy;
   assign result.done_res      = done;
   assign result.received_word = done ? in_shift_in : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         clock_high_ff <= 1'b0;
         bit_index_ff  <= '0;
         tick_count_ff <= '0;
         out_shift_ff  <= '0;
         in_shift_ff   <= '0;
         length_ff     <= DefaultCount;
         target_ff     <= 1'b0;
      end else if (tick) begin
         phase_ff      <= phase_in;
         clock_high_ff <= clock_high_in;
         bit_index_ff  <= bit_index_in;
         tick_count_ff <= tick_count_in;
         out_shift_ff  <= out_shift_in;
         in_shift_ff   <= in_shift_in;
         length_ff     <= length_in;
         target_ff     <= target_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/spim_out.sv
// result register between the engine and the rsp stream
`default_nettype none
module spim_out (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   output      logic                             in_ready,
   input  wire spim_pkg::result_type             in_result,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [spim_pkg::RspDataW-1:0]    rsp_tdata
);
   import spim_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;
   logic       load;

   assign in_ready = !valid_ff || rsp_tready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = in_result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RspDataW'(data_ff);

endmodule
`default_nettype wire

FILE: rtl/core/spi_master_with_length_header_unit.sv
// top level of the spi mode-0 master with optional length header
//
// every req transaction is one timing tick of the pin engine; for each one the
// block returns exactly one rsp transaction with the pin levels after that tick
// (sclk, mosi, both active-low selects), busy, a one-tick done flag and the
// received word, which is nonzero only on the done tick.
// a tick with start_req set while idle latches the slave, word and bit count
// and starts a transfer: an 8-bit count header (if enabled), then the data bits
// full duplex msb first, each bit lasting two halves of half_period ticks.
// rsp_tvalid rises in the cycle after req acceptance. throughput: one tick per
// cycle while rsp_tready is high, set by the single result register after the
// engine state update. when rsp_tready is low and a result is held, req_tready
// drops and the engine does not advance; no tick is lost or repeated.
// the csr channel is always ready: index 0 writes half_period, index 1 writes
// header_enable; write only between transfers.
// reset (synchronous): engine idle, selects high, half_period 250, header on,
// no rsp pending.
`default_nettype none
module spi_master_with_length_header_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // tdata: start_req, send_word[31:0], bit_count[5:0], miso_bit
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [spim_pkg::ReqDataW-1:0]   req_tdata,
   // tuser: slave_select
   input  wire logic                            req_tuser,
   // tdata: sclk, mosi, cs_one_n, cs_two_n, busy_res, done_res, received_word[31:0]
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [spim_pkg::RspDataW-1:0]   rsp_tdata,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [spim_pkg::CsrIndexW-1:0]  csr_index,
   input  wire logic [spim_pkg::HalfW-1:0]      csr_data
);
   import spim_pkg::*;

   cfg_type    cfg;
   result_type result;
   logic       tick;

   assign tick = req_tvalid && req_tready;

   spim_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   spim_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .tick         (tick),
      .start_req    (req_tdata[0]),
      .slave_select (req_tuser),
      .send_word    (req_tdata[WordW:1]),
      .bit_count    (req_tdata[WordW+CountW:WordW+1]),
      .miso_bit     (req_tdata[WordW+CountW+1]),
      .cfg          (cfg),
      .result       (result)
   );

   spim_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_result  (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
